[rtl/vfa_pkg.sv]
// Shared constants, types and helpers for the 2D fixed-point vector unit.
package vfa_pkg;

    localparam int CW    = 32;        // component width
    localparam int FB    = 16;        // fraction bits
    localparam int MW    = 4;         // mode field width
    localparam int PW    = 2 * CW;    // product width
    localparam int RW    = CW;        // root width
    localparam int QW    = FB + 1;    // quotient bits of a normalised component
    localparam int DW    = RW + 1;    // divider remainder width
    localparam int NLANE = 4;

    localparam int LANE_AX = 0;
    localparam int LANE_AY = 1;
    localparam int LANE_BX = 2;
    localparam int LANE_BY = 3;

    typedef logic signed [CW-1:0] t_comp;
    typedef logic [CW-1:0]        t_ucomp;
    typedef logic [PW-1:0]        t_rad;
    typedef logic [RW-1:0]        t_root;

    localparam t_comp CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_comp CMIN = {1'b1, {(CW-1){1'b0}}};

    typedef enum logic [MW-1:0] {
        MODE_ADD     = 4'd0,
        MODE_SUB     = 4'd1,
        MODE_DOT     = 4'd2,
        MODE_CROSS   = 4'd3,
        MODE_MAG     = 4'd4,
        MODE_NORM    = 4'd5,
        MODE_SCALE   = 4'd6,
        MODE_NEG     = 4'd7,
        MODE_EQ      = 4'd8,
        MODE_UNIT_EQ = 4'd9,
        MODE_NONZERO = 4'd10
    } t_mode;

    // Result fields and what the late stages still need, carried down the pipe.
    typedef struct packed {
        t_mode                        mode;
        t_comp                        ox;
        t_comp                        oy;
        t_comp                        sc;
        logic                         flag;
        logic                         sat;
        logic [NLANE-1:0][CW-1:0]     cabs;
        logic [NLANE-1:0]             neg;
    } t_item;

    typedef struct packed {
        t_comp v;
        logic  sat;
    } t_clamp;

    function automatic t_clamp clamp_sat(input logic signed [PW:0] v);
        t_clamp r;
        r.sat = !((&v[PW:CW-1]) || (~|v[PW:CW-1]));
        r.v   = r.sat ? (v[PW] ? CMIN : CMAX) : t_comp'(v[CW-1:0]);
        return r;
    endfunction

endpackage

[rtl/vfa_front.sv]
// Front end: input register, products, sums, shifts and clamps.
module vfa_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [3:0]     i_mode,
    input  vfa_pkg::t_comp i_ax,
    input  vfa_pkg::t_comp i_ay,
    input  vfa_pkg::t_comp i_bx,
    input  vfa_pkg::t_comp i_by,
    input  vfa_pkg::t_comp i_s,
    output logic           o_valid,
    output vfa_pkg::t_item o_item,
    output vfa_pkg::t_rad  o_na,
    output vfa_pkg::t_rad  o_nb
);
    import vfa_pkg::*;

    // stage 1: input register
    logic  r1_valid;
    t_mode r1_mode;
    t_comp r1_ax, r1_ay, r1_bx, r1_by, r1_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mode <= t_mode'(i_mode);
            r1_ax   <= i_ax;
            r1_ay   <= i_ay;
            r1_bx   <= i_bx;
            r1_by   <= i_by;
            r1_s    <= i_s;
        end
    end

    // stage 2: multipliers and the simple modes
    t_comp                   m0, m1;
    logic signed [CW:0]      sx, sy;
    logic                    flg;
    logic signed [PW-1:0]    p0, p1, p2, p3;
    t_clamp                  cx, cy;
    logic [NLANE-1:0][CW-1:0] cabs;
    logic [NLANE-1:0]        neg;

    always_comb begin
        m0  = r1_ax;
        m1  = r1_ay;
        sx  = '0;
        sy  = '0;
        flg = 1'b0;
        unique case (r1_mode)
            MODE_ADD: begin
                sx = (CW+1)'(r1_ax) + (CW+1)'(r1_bx);
                sy = (CW+1)'(r1_ay) + (CW+1)'(r1_by);
            end
            MODE_SUB: begin
                sx = (CW+1)'(r1_ax) - (CW+1)'(r1_bx);
                sy = (CW+1)'(r1_ay) - (CW+1)'(r1_by);
            end
            MODE_NEG: begin
                sx = -((CW+1)'(r1_ax));
                sy = -((CW+1)'(r1_ay));
            end
            MODE_DOT: begin
                m0 = r1_bx;
                m1 = r1_by;
            end
            MODE_CROSS: begin
                m0 = r1_by;
                m1 = r1_bx;
            end
            MODE_SCALE: begin
                m0 = r1_s;
                m1 = r1_s;
            end
            MODE_EQ:      flg = (r1_ax == r1_bx) && (r1_ay == r1_by);
            MODE_NONZERO: flg = (r1_ax != '0) || (r1_ay != '0);
            default: ;
        endcase
        p0 = PW'(r1_ax) * PW'(m0);
        p1 = PW'(r1_ay) * PW'(m1);
        p2 = PW'(r1_bx) * PW'(r1_bx);
        p3 = PW'(r1_by) * PW'(r1_by);
        cx = clamp_sat((PW+1)'(sx));
        cy = clamp_sat((PW+1)'(sy));
        cabs[LANE_AX] = r1_ax[CW-1] ? t_ucomp'(-r1_ax) : t_ucomp'(r1_ax);
        cabs[LANE_AY] = r1_ay[CW-1] ? t_ucomp'(-r1_ay) : t_ucomp'(r1_ay);
        cabs[LANE_BX] = r1_bx[CW-1] ? t_ucomp'(-r1_bx) : t_ucomp'(r1_bx);
        cabs[LANE_BY] = r1_by[CW-1] ? t_ucomp'(-r1_by) : t_ucomp'(r1_by);
        neg = {r1_by[CW-1], r1_bx[CW-1], r1_ay[CW-1], r1_ax[CW-1]};
    end

    logic                 r2_valid;
    t_item                r2_item;
    logic signed [PW-1:0] r2_p0, r2_p1, r2_p2, r2_p3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_item.mode <= r1_mode;
            r2_item.ox   <= cx.v;
            r2_item.oy   <= cy.v;
            r2_item.sc   <= '0;
            r2_item.flag <= flg;
            r2_item.sat  <= cx.sat | cy.sat;
            r2_item.cabs <= cabs;
            r2_item.neg  <= neg;
            r2_p0        <= p0;
            r2_p1        <= p1;
            r2_p2        <= p2;
            r2_p3        <= p3;
        end
    end

    // stage 3: wide sums, shift back to the fixed-point scale, clamp
    logic signed [PW:0] w;
    t_clamp             cw, sx3, sy3;
    t_item              n_item;

    always_comb begin
        n_item = r2_item;
        w      = '0;
        unique case (r2_item.mode)
            MODE_DOT:   w = (PW+1)'(r2_p0) + (PW+1)'(r2_p1);
            MODE_CROSS: w = (PW+1)'(r2_p0) - (PW+1)'(r2_p1);
            default: ;
        endcase
        cw  = clamp_sat(w >>> FB);
        sx3 = clamp_sat((PW+1)'(r2_p0 >>> FB));
        sy3 = clamp_sat((PW+1)'(r2_p1 >>> FB));
        n_item.sc  = cw.v;
        n_item.sat = r2_item.sat | cw.sat;
        if (r2_item.mode == MODE_SCALE) begin
            n_item.ox  = sx3.v;
            n_item.oy  = sy3.v;
            n_item.sat = sx3.sat | sy3.sat;
        end
    end

    logic  r3_valid;
    t_item r3_item;
    t_rad  r3_na, r3_nb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_item <= n_item;
            r3_na   <= t_rad'(r2_p0) + t_rad'(r2_p1);
            r3_nb   <= t_rad'(r2_p2) + t_rad'(r2_p3);
        end
    end

    assign o_valid = r3_valid;
    assign o_item  = r3_item;
    assign o_na    = r3_na;
    assign o_nb    = r3_nb;

endmodule

[rtl/vfa_sqrt.sv]
// Pipelined bitwise square root, one root bit per stage, two radicands.
module vfa_sqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  vfa_pkg::t_item i_item,
    input  vfa_pkg::t_rad  i_na,
    input  vfa_pkg::t_rad  i_nb,
    output logic           o_valid,
    output vfa_pkg::t_item o_item,
    output vfa_pkg::t_root o_ma,
    output vfa_pkg::t_root o_mb
);
    import vfa_pkg::*;

    logic  r_vld  [RW];
    t_item r_item [RW];
    t_rad  r_ra   [RW];
    t_rad  r_rb   [RW];
    t_root r_qa   [RW];
    t_root r_qb   [RW];

    for (genvar k = 0; k < RW; k++) begin : g_st
        localparam int B = RW - 1 - k;
        logic        v_in;
        t_item       it_in;
        t_rad        ra_in, rb_in;
        t_root       qa_in, qb_in;
        logic [PW:0] ta, tb;

        if (k == 0) begin : g_first
            assign v_in  = i_valid;
            assign it_in = i_item;
            assign ra_in = i_na;
            assign rb_in = i_nb;
            assign qa_in = '0;
            assign qb_in = '0;
        end else begin : g_next
            assign v_in  = r_vld[k-1];
            assign it_in = r_item[k-1];
            assign ra_in = r_ra[k-1];
            assign rb_in = r_rb[k-1];
            assign qa_in = r_qa[k-1];
            assign qb_in = r_qb[k-1];
        end

        // (r + 2^B)^2 - r^2
        assign ta = ((PW+1)'(qa_in) << (B + 1)) + ((PW+1)'(1) << (2 * B));
        assign tb = ((PW+1)'(qb_in) << (B + 1)) + ((PW+1)'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_item[k] <= it_in;
                if ({1'b0, ra_in} >= ta) begin
                    r_ra[k] <= ra_in - ta[PW-1:0];
                    r_qa[k] <= qa_in | (RW'(1) << B);
                end else begin
                    r_ra[k] <= ra_in;
                    r_qa[k] <= qa_in;
                end
                if ({1'b0, rb_in} >= tb) begin
                    r_rb[k] <= rb_in - tb[PW-1:0];
                    r_qb[k] <= qb_in | (RW'(1) << B);
                end else begin
                    r_rb[k] <= rb_in;
                    r_qb[k] <= qb_in;
                end
            end
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_item  = r_item[RW-1];
    assign o_ma    = r_qa[RW-1];
    assign o_mb    = r_qb[RW-1];

endmodule

[rtl/vfa_div.sv]
// Pipelined restoring divider: each component over its vector's magnitude.
module vfa_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  vfa_pkg::t_item i_item,
    input  vfa_pkg::t_root i_ma,
    input  vfa_pkg::t_root i_mb,
    output logic           o_valid,
    output vfa_pkg::t_item o_item,
    output vfa_pkg::t_root o_ma,
    output vfa_pkg::t_root o_mb,
    output logic [vfa_pkg::NLANE-1:0][vfa_pkg::QW-1:0] o_quo
);
    import vfa_pkg::*;

    logic                         r_vld  [QW];
    t_item                        r_item [QW];
    t_root                        r_ma   [QW];
    t_root                        r_mb   [QW];
    logic [NLANE-1:0][DW-1:0]     r_rem  [QW];
    logic [NLANE-1:0][QW-1:0]     r_quo  [QW];

    for (genvar s = 0; s < QW; s++) begin : g_st
        logic                     v_in;
        t_item                    it_in;
        t_root                    ma_in, mb_in;
        logic [NLANE-1:0][DW-1:0] trial, rem_n;
        logic [NLANE-1:0][QW-1:0] quo_in, quo_n;
        logic [DW-1:0]            dv;

        if (s == 0) begin : g_first
            assign v_in   = i_valid;
            assign it_in  = i_item;
            assign ma_in  = i_ma;
            assign mb_in  = i_mb;
            assign quo_in = '0;
            for (genvar l = 0; l < NLANE; l++) begin : g_ln
                assign trial[l] = DW'(i_item.cabs[l]);
            end
        end else begin : g_next
            assign v_in   = r_vld[s-1];
            assign it_in  = r_item[s-1];
            assign ma_in  = r_ma[s-1];
            assign mb_in  = r_mb[s-1];
            assign quo_in = r_quo[s-1];
            for (genvar l = 0; l < NLANE; l++) begin : g_ln
                assign trial[l] = r_rem[s-1][l] << 1;
            end
        end

        always_comb begin
            dv = '0;
            for (int l = 0; l < NLANE; l++) begin
                dv = (l == LANE_AX || l == LANE_AY) ? DW'(ma_in) : DW'(mb_in);
                if (trial[l] >= dv) begin
                    rem_n[l] = trial[l] - dv;
                    quo_n[l] = {quo_in[l][QW-2:0], 1'b1};
                end else begin
                    rem_n[l] = trial[l];
                    quo_n[l] = {quo_in[l][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_item[s] <= it_in;
                r_ma[s]   <= ma_in;
                r_mb[s]   <= mb_in;
                r_rem[s]  <= rem_n;
                r_quo[s]  <= quo_n;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_item  = r_item[QW-1];
    assign o_ma    = r_ma[QW-1];
    assign o_mb    = r_mb[QW-1];
    assign o_quo   = r_quo[QW-1];

endmodule

[rtl/vector2_fixed_point_alu_top.sv]
// Top level of the 2D fixed-point vector unit: pipe assembly and output register.
//
//  channel | valid    | stall     | payload
//  --------+----------+-----------+-----------------------------------------------
//  in      | i_valid  | o_stall   | i_mode, i_first_x/y, i_second_x/y, i_scale_factor
//  out     | o_valid  | i_stall   | o_out_x, o_out_y, o_scalar_out, o_flag, o_saturated
//
// One transfer in per cycle while o_stall is low, components in Q16.16. The pipe
// is the front end, one square-root stage per root bit and one divider
// stage per quotient bit, plus the output register.
// Reset clears every stage's valid bit. The whole pipe freezes while a result
// waits in the output register and i_stall is high; o_stall follows from that.
module vector2_fixed_point_alu_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [3:0]     i_mode,
    input  vfa_pkg::t_comp i_first_x,
    input  vfa_pkg::t_comp i_first_y,
    input  vfa_pkg::t_comp i_second_x,
    input  vfa_pkg::t_comp i_second_y,
    input  vfa_pkg::t_comp i_scale_factor,
    output logic           o_valid,
    input  logic           i_stall,
    output vfa_pkg::t_comp o_out_x,
    output vfa_pkg::t_comp o_out_y,
    output vfa_pkg::t_comp o_scalar_out,
    output logic           o_flag,
    output logic           o_saturated
);
    import vfa_pkg::*;

    logic  en;
    logic  f_valid, s_valid, d_valid;
    t_item f_item, s_item, d_item;
    t_rad  f_na, f_nb;
    t_root s_ma, s_mb, d_ma, d_mb;
    logic [NLANE-1:0][QW-1:0] d_quo;

    logic  r_valid;
    t_comp r_ox, r_oy, r_sc;
    logic  r_flag, r_sat;

    assign en      = !r_valid || !i_stall;
    assign o_stall = !en;

    vfa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .i_ax    (i_first_x),
        .i_ay    (i_first_y),
        .i_bx    (i_second_x),
        .i_by    (i_second_y),
        .i_s     (i_scale_factor),
        .o_valid (f_valid),
        .o_item  (f_item),
        .o_na    (f_na),
        .o_nb    (f_nb)
    );

    vfa_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_item  (f_item),
        .i_na    (f_na),
        .i_nb    (f_nb),
        .o_valid (s_valid),
        .o_item  (s_item),
        .o_ma    (s_ma),
        .o_mb    (s_mb)
    );

    vfa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_item  (s_item),
        .i_ma    (s_ma),
        .i_mb    (s_mb),
        .o_valid (d_valid),
        .o_item  (d_item),
        .o_ma    (d_ma),
        .o_mb    (d_mb),
        .o_quo   (d_quo)
    );

    // signed normalised components; a zero vector gives zero
    t_comp nv [NLANE];
    logic  mzero;
    t_comp n_ox, n_oy, n_sc;
    logic  n_flag, n_sat;

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            mzero = (l == LANE_AX || l == LANE_AY) ? (d_ma == '0) : (d_mb == '0);
            if (mzero) begin
                nv[l] = '0;
            end else if (d_item.neg[l]) begin
                nv[l] = -t_comp'(d_quo[l]);
            end else begin
                nv[l] = t_comp'(d_quo[l]);
            end
        end
        n_ox   = d_item.ox;
        n_oy   = d_item.oy;
        n_sc   = d_item.sc;
        n_flag = d_item.flag;
        n_sat  = d_item.sat;
        unique case (d_item.mode)
            MODE_MAG: begin
                n_sat = d_ma > t_root'(CMAX);
                n_sc  = n_sat ? CMAX : t_comp'(d_ma);
            end
            MODE_NORM: begin
                n_ox  = nv[LANE_AX];
                n_oy  = nv[LANE_AY];
                n_sat = 1'b0;
            end
            MODE_UNIT_EQ: begin
                n_flag = (nv[LANE_AX] == nv[LANE_BX]) && (nv[LANE_AY] == nv[LANE_BY]);
                n_sat  = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ox   <= n_ox;
            r_oy   <= n_oy;
            r_sc   <= n_sc;
            r_flag <= n_flag;
            r_sat  <= n_sat;
        end
    end

    assign o_valid      = r_valid;
    assign o_out_x      = r_ox;
    assign o_out_y      = r_oy;
    assign o_scalar_out = r_sc;
    assign o_flag       = r_flag;
    assign o_saturated  = r_sat;

endmodule

[dv/tb.sv]
// Self-checking testbench for the 2D fixed-point vector unit.
`timescale 1ns / 100ps

module tb;
    import vfa_pkg::*;

    typedef struct {
        logic [3:0] mode;
        t_comp      ax, ay, bx, by, s;
    } t_vec_op;

    typedef struct {
        t_comp ox, oy, sc;
        logic  flag, sat;
    } t_vec_res;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       i_stall = 1'b0;
    logic [3:0] i_mode = '0;
    t_comp      i_first_x = '0, i_first_y = '0, i_second_x = '0, i_second_y = '0;
    t_comp      i_scale_factor = '0;
    logic       o_stall, o_valid, o_flag, o_saturated;
    t_comp      o_out_x, o_out_y, o_scalar_out;

    t_vec_op  op_q[$];
    t_vec_res result_q[$];
    t_vec_op  cur_op;
    int       n_mismatch = 0;
    int       n_sent = 0;
    int       drain_at = 700;
    int       burst_left = 0, gap_left = 0;
    int       stall_left = 0, stall_mode = 0;
    int       cycles = 0;
    bit       stim_done = 1'b0;

    vector2_fixed_point_alu_top u_top (.*);

    always #4 i_clk = ~i_clk;

    function automatic t_comp sat_clip(input logic signed [127:0] v, inout logic sat);
        if (v > 128'sh7fffffff) begin
            sat = 1'b1;
            return CMAX;
        end
        if (v < -128'sh80000000) begin
            sat = 1'b1;
            return CMIN;
        end
        return t_comp'(v[31:0]);
    endfunction

    function automatic logic [63:0] vec_length(input t_comp x, input t_comp y);
        logic signed [127:0] ex, ey, n, c;
        logic [63:0] r;
        ex = 128'(x);
        ey = 128'(y);
        n = ex * ex + ey * ey;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = 128'(r | (64'd1 << b));
            if (c * c <= n) r = c[63:0];
        end
        return r;
    endfunction

    function automatic t_comp unit_comp(input t_comp c, input logic [63:0] len);
        logic [63:0] u, q;
        logic signed [127:0] v;
        logic d;
        if (len == 0) return '0;
        u = c < 0 ? 64'(-64'sd1 * 64'(signed'(c))) : 64'(c);
        q = (u << FB) / len;
        v = c < 0 ? -$signed({64'd0, q}) : $signed({64'd0, q});
        d = 1'b0;
        return sat_clip(v, d);
    endfunction

    function automatic t_vec_res vec_compute(input t_vec_op o);
        t_vec_res r;
        logic signed [127:0] ax, ay, bx, by, s, w;
        logic [63:0] la, lb;
        r = '{default: '0};
        ax = 128'(o.ax); ay = 128'(o.ay); bx = 128'(o.bx); by = 128'(o.by);
        s = 128'(o.s);
        case (o.mode)
            MODE_ADD: begin
                r.ox = sat_clip(ax + bx, r.sat);
                r.oy = sat_clip(ay + by, r.sat);
            end
            MODE_SUB: begin
                r.ox = sat_clip(ax - bx, r.sat);
                r.oy = sat_clip(ay - by, r.sat);
            end
            MODE_DOT: begin
                w = (ax * bx + ay * by) >>> FB;
                r.sc = sat_clip(w, r.sat);
            end
            MODE_CROSS: begin
                w = (ax * by - ay * bx) >>> FB;
                r.sc = sat_clip(w, r.sat);
            end
            MODE_MAG: begin
                la = vec_length(o.ax, o.ay);
                r.sc = sat_clip($signed({64'd0, la}), r.sat);
            end
            MODE_NORM: begin
                la = vec_length(o.ax, o.ay);
                r.ox = unit_comp(o.ax, la);
                r.oy = unit_comp(o.ay, la);
            end
            MODE_SCALE: begin
                r.ox = sat_clip((ax * s) >>> FB, r.sat);
                r.oy = sat_clip((ay * s) >>> FB, r.sat);
            end
            MODE_NEG: begin
                r.ox = sat_clip(-ax, r.sat);
                r.oy = sat_clip(-ay, r.sat);
            end
            MODE_EQ: r.flag = (o.ax == o.bx) && (o.ay == o.by);
            MODE_UNIT_EQ: begin
                la = vec_length(o.ax, o.ay);
                lb = vec_length(o.bx, o.by);
                r.flag = unit_comp(o.ax, la) == unit_comp(o.bx, lb)
                    && unit_comp(o.ay, la) == unit_comp(o.by, lb);
            end
            MODE_NONZERO: r.flag = (o.ax != 0) || (o.ay != 0);
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_comp rand_comp();
        case ($urandom_range(0, 5))
            0: return t_comp'($urandom_range(0, 8) == 0 ? CMAX : CMIN + $urandom_range(0, 1));
            1: return t_comp'($signed($urandom_range(0, 16'hffff)) - 32768);
            2: return t_comp'($signed($urandom_range(0, 32'h7ffff)) - 32'sh40000);
            3: return '0;
            default: return t_comp'($urandom());
        endcase
    endfunction

    task automatic add_op(input logic [3:0] m, input t_comp ax, input t_comp ay,
                          input t_comp bx, input t_comp by, input t_comp s);
        t_vec_op o;
        o.mode = m; o.ax = ax; o.ay = ay; o.bx = bx; o.by = by; o.s = s;
        op_q.push_back(o);
    endtask

    initial begin
        t_vec_op o;
        int k;
        add_op(MODE_ADD, CMAX, CMIN, CMAX, CMIN, 0);
        add_op(MODE_SUB, CMIN, CMAX, CMAX, CMIN, 0);
        add_op(MODE_DOT, CMIN, CMIN, CMIN, CMIN, 0);
        add_op(MODE_DOT, 32'sh10000, -32'sh20000, 32'sh30000, 32'sh8000, 0);
        add_op(MODE_CROSS, CMAX, CMIN, CMAX, CMIN, 0);
        add_op(MODE_CROSS, -1, 1, 1, -1, 0);
        add_op(MODE_MAG, CMIN, CMIN, 0, 0, 0);
        add_op(MODE_MAG, 32'sh30000, 32'sh40000, 0, 0, 0);
        add_op(MODE_NORM, 0, 0, 0, 0, 0);
        add_op(MODE_NORM, CMIN, CMAX, 0, 0, 0);
        add_op(MODE_NORM, -3, 4, 0, 0, 0);
        add_op(MODE_SCALE, CMAX, CMIN, 0, 0, CMIN);
        add_op(MODE_SCALE, -32'sh18000, 32'sh7, 0, 0, 32'sh10000);
        add_op(MODE_NEG, CMIN, CMAX, 0, 0, 0);
        add_op(MODE_EQ, CMIN, CMAX, CMIN, CMAX, 0);
        add_op(MODE_EQ, 5, 6, 5, 7, 0);
        add_op(MODE_UNIT_EQ, 1, 2, 32'sh10000, 32'sh20000, 0);
        add_op(MODE_UNIT_EQ, 0, 0, 0, 0, 0);
        add_op(MODE_UNIT_EQ, CMIN, 0, -1, 0, 0);
        add_op(MODE_NONZERO, 0, 0, 0, 0, 0);
        add_op(MODE_NONZERO, 0, CMIN, 0, 0, 0);
        add_op(4'd11, CMAX, CMAX, CMAX, CMAX, CMAX);
        add_op(4'd15, -1, -1, -1, -1, -1);
        for (int i = 0; i < 1500; i++) begin
            o.mode = $urandom_range(0, 15) == 0 ? 4'($urandom_range(11, 15))
                                                 : 4'($urandom_range(0, 10));
            o.ax = rand_comp(); o.ay = rand_comp();
            o.bx = rand_comp(); o.by = rand_comp(); o.s = rand_comp();
            if ((o.mode == MODE_EQ || o.mode == MODE_UNIT_EQ) && $urandom_range(0, 1)) begin
                k = o.mode == MODE_UNIT_EQ ? $urandom_range(1, 4) : 1;
                o.ax = t_comp'($signed($urandom_range(0, 4095)) - 2048);
                o.ay = t_comp'($signed($urandom_range(0, 4095)) - 2048);
                o.bx = t_comp'(o.ax * k);
                o.by = t_comp'(o.ay * k);
                if ($urandom_range(0, 3) == 0) o.by = o.by + 1;
            end
            op_q.push_back(o);
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // sender: bursts and gaps, one hold-off until the pipe has drained
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                result_q.push_back(vec_compute(cur_op));
                n_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (op_q.size() == 0
                             || (n_sent == drain_at && result_q.size() != 0)) begin
                    i_valid <= 1'b0;
                    if (op_q.size() == 0) stim_done <= 1'b1;
                end else begin
                    cur_op = op_q.pop_front();
                    i_valid <= 1'b1;
                    i_mode <= cur_op.mode;
                    i_first_x <= cur_op.ax;
                    i_first_y <= cur_op.ay;
                    i_second_x <= cur_op.bx;
                    i_second_y <= cur_op.by;
                    i_scale_factor <= cur_op.s;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // receiver: stall pattern with free-running stretches
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (result_q.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) $display("unexpected transfer out");
                end else begin
                    t_vec_res e;
                    e = result_q.pop_front();
                    if (e.ox !== o_out_x || e.oy !== o_out_y || e.sc !== o_scalar_out
                        || e.flag !== o_flag || e.sat !== o_saturated) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("mismatch exp x=%h y=%h s=%h f=%b sat=%b got x=%h y=%h s=%h f=%b sat=%b",
                                     e.ox, e.oy, e.sc, e.flag, e.sat, o_out_x, o_out_y,
                                     o_scalar_out, o_flag, o_saturated);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
            end else begin
                stall_left = $urandom_range(5, 60);
                stall_mode = $urandom_range(0, 2);
            end
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= $urandom_range(0, 3) == 0;
                default: i_stall <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        wait (stim_done && !i_valid && result_q.size() == 0);
        repeat (80) @(posedge i_clk);
        if (n_mismatch == 0 && result_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
